FILE: design/swpfc_pkg.sv
// ----------------------------------------------------------------------------
// swpfc_pkg
// Shared types and constants of the single-wire pulse and frame codec.
// ----------------------------------------------------------------------------
`default_nettype none

package swpfc_pkg;

    // input item kinds (tuser of the slave side)
    localparam logic [2:0] KIND_CALIBRATE = 3'd0;
    localparam logic [2:0] KIND_HEADER    = 3'd1;
    localparam logic [2:0] KIND_BYTE      = 3'd2;
    localparam logic [2:0] KIND_PULSE     = 3'd3;
    localparam logic [2:0] KIND_ARM       = 3'd4;

    // configuration register indexes
    localparam logic CFG_SYNC_MIN = 1'b0;
    localparam logic CFG_SYNC_MAX = 1'b1;

    localparam logic [15:0] SYNC_MIN_RESET = 16'd50;
    localparam logic [15:0] SYNC_MAX_RESET = 16'd1000;

    localparam int RX_BUF_SIZE = 32;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam int HDR_SYMS  = 5;
    localparam int BYTE_SYMS = 10;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 2;

    typedef enum logic [1:0] {
        CMD_STATUS = 2'd0,
        CMD_FRAME  = 2'd1,
        CMD_RX     = 2'd2
    } cmd_op_t;

    // status: word[0]; frame: word[9:0] symbols in send order from bit 0;
    // rx: received word
    typedef struct packed {
        cmd_op_t     op;
        logic [31:0] word;
        logic [3:0]  nsym;
    } cmd_t;

endpackage : swpfc_pkg

`default_nettype wire

FILE: design/swpfc_front.sv
// ----------------------------------------------------------------------------
// swpfc_front
// Accepts input items, keeps calibration and receive state, and turns every
// item that yields results into one command for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module swpfc_front
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [2:0]           kind,
    input  wire logic [7:0]           payload,
    input  wire logic [15:0]          pulse_width,
    input  wire logic                 q_full,
    output logic                      q_push,
    output swpfc_pkg::cmd_t           q_cmd
);

    logic [15:0] sync_min_reg;
    logic [15:0] sync_max_reg;
    logic [10:0] thr_reg,      thr_next;
    logic        armed_reg,    armed_next;
    logic [5:0]  expected_reg, expected_next;
    logic [5:0]  count_reg,    count_next;
    logic [31:0] shift_reg,    shift_next;

    logic        accept;
    logic        out_of_range;
    logic        rx_bit;
    logic [7:0]  arm_n;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;

    assign out_of_range = (pulse_width < sync_min_reg) || (pulse_width > sync_max_reg);
    assign rx_bit       = pulse_width < {5'd0, thr_reg};
    assign arm_n        = (payload > 8'(swpfc_pkg::RX_BUF_SIZE))
                          ? 8'(swpfc_pkg::RX_BUF_SIZE) : payload;

    always_comb
    begin
        thr_next      = thr_reg;
        armed_next    = armed_reg;
        expected_next = expected_reg;
        count_next    = count_reg;
        shift_next    = shift_reg;
        q_push        = 1'b0;
        q_cmd.op      = swpfc_pkg::CMD_STATUS;
        q_cmd.word    = 32'd0;
        q_cmd.nsym    = 4'd0;
        if (accept)
        begin
            unique case (kind)
                swpfc_pkg::KIND_CALIBRATE:
                begin
                    q_push        = 1'b1;
                    q_cmd.word[0] = out_of_range;
                    if (!out_of_range)
                    begin
                        thr_next = pulse_width[15:5];
                    end
                end
                swpfc_pkg::KIND_HEADER:
                begin
                    q_push     = 1'b1;
                    q_cmd.op   = swpfc_pkg::CMD_FRAME;
                    q_cmd.word = {27'd0, payload[0], payload[1], payload[2],
                                  payload[3], 1'b0};
                    q_cmd.nsym = 4'(swpfc_pkg::HDR_SYMS);
                end
                swpfc_pkg::KIND_BYTE:
                begin
                    q_push     = 1'b1;
                    q_cmd.op   = swpfc_pkg::CMD_FRAME;
                    q_cmd.word = {22'd0, ^payload, payload[0], payload[1], payload[2],
                                  payload[3], payload[4], payload[5], payload[6],
                                  payload[7], 1'b0};
                    q_cmd.nsym = 4'(swpfc_pkg::BYTE_SYMS);
                end
                swpfc_pkg::KIND_PULSE:
                begin
                    if (armed_reg)
                    begin
                        shift_next = {shift_reg[30:0], rx_bit};
                        count_next = count_reg + 6'd1;
                        if (count_next >= expected_reg)
                        begin
                            armed_next = 1'b0;
                            q_push     = 1'b1;
                            q_cmd.op   = swpfc_pkg::CMD_RX;
                            q_cmd.word = shift_next;
                        end
                    end
                end
                swpfc_pkg::KIND_ARM:
                begin
                    expected_next = arm_n[5:0];
                    count_next    = 6'd0;
                    shift_next    = 32'd0;
                    armed_next    = arm_n != 8'd0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_min_reg <= swpfc_pkg::SYNC_MIN_RESET;
            sync_max_reg <= swpfc_pkg::SYNC_MAX_RESET;
            thr_reg      <= '0;
            armed_reg    <= 1'b0;
            expected_reg <= '0;
            count_reg    <= '0;
            shift_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    swpfc_pkg::CFG_SYNC_MIN: sync_min_reg <= cfg_data;
                    swpfc_pkg::CFG_SYNC_MAX: sync_max_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            thr_reg      <= thr_next;
            armed_reg    <= armed_next;
            expected_reg <= expected_next;
            count_reg    <= count_next;
            shift_reg    <= shift_next;
        end
    end

endmodule : swpfc_front

`default_nettype wire

FILE: design/swpfc_queue.sv
// ----------------------------------------------------------------------------
// swpfc_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module swpfc_queue
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire swpfc_pkg::cmd_t      push_cmd,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      head_valid,
    output swpfc_pkg::cmd_t           head_cmd
);

    localparam int CNT_W = $clog2(swpfc_pkg::QDEPTH + 1);

    swpfc_pkg::cmd_t                  mem_reg [swpfc_pkg::QDEPTH];
    logic [swpfc_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [swpfc_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]                 cnt_reg,    cnt_next;

    assign full       = cnt_reg == CNT_W'(swpfc_pkg::QDEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule : swpfc_queue

`default_nettype wire

FILE: design/swpfc_back.sv
// ----------------------------------------------------------------------------
// swpfc_back
// Takes commands from the queue and emits one result per cycle into the output
// register while it is not stalled; frames are shifted out one symbol at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module swpfc_back
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           head_valid,
    input  wire swpfc_pkg::cmd_t                head_cmd,
    output logic                                pop,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [swpfc_pkg::OUT_DATA_W-1:0]    out_data,
    output logic [swpfc_pkg::OUT_USER_W-1:0]    out_user,
    output logic                                out_last
);

    logic                                   cur_valid_reg, cur_valid_next;
    swpfc_pkg::cmd_t                        cur_reg,       cur_next;
    logic                                   ov_reg,        ov_next;
    logic [swpfc_pkg::OUT_DATA_W-1:0]       od_reg,        od_next;
    logic [swpfc_pkg::OUT_USER_W-1:0]       ou_reg,        ou_next;
    logic                                   ol_reg,        ol_next;

    logic        load_out;
    logic        advance;
    logic        cur_fin;
    logic [31:0] w;
    logic [7:0]  rx_byte;

    assign load_out = !ov_reg || out_ready;
    assign advance  = load_out && cur_valid_reg;
    assign cur_fin  = (cur_reg.op != swpfc_pkg::CMD_FRAME) || (cur_reg.nsym == 4'd1);
    assign pop      = head_valid && (!cur_valid_reg || (advance && cur_fin));
    assign w        = cur_reg.word;
    assign rx_byte  = w[8:1];

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            cur_next       = head_cmd;
        end
        else if (advance)
        begin
            if (cur_fin)
            begin
                cur_valid_next = 1'b0;
            end
            else
            begin
                cur_next.word = {1'b0, cur_reg.word[31:1]};
                cur_next.nsym = cur_reg.nsym - 4'd1;
            end
        end
    end

    // tdata: status, sym_bit, rx_word, rx_ack, rx_data_byte, rx_parity_ok,
    // rx_start_ok; tuser: sym_valid, rx_done
    always_comb
    begin
        ov_next = ov_reg;
        od_next = od_reg;
        ou_next = ou_reg;
        ol_next = ol_reg;
        if (load_out)
        begin
            ov_next = cur_valid_reg;
            od_next = '0;
            ou_next = '0;
            ol_next = 1'b0;
            unique case (cur_reg.op)
                swpfc_pkg::CMD_STATUS:
                begin
                    od_next[0] = w[0];
                end
                swpfc_pkg::CMD_FRAME:
                begin
                    ou_next[0] = 1'b1;
                    od_next[1] = w[0];
                    ol_next    = cur_reg.nsym == 4'd1;
                end
                swpfc_pkg::CMD_RX:
                begin
                    ou_next[1]     = 1'b1;
                    od_next[33:2]  = w;
                    od_next[34]    = w[0];
                    od_next[42:35] = rx_byte;
                    od_next[43]    = w[0] == ^rx_byte;
                    od_next[44]    = w[9];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        od_reg  <= od_next;
        ou_reg  <= ou_next;
        ol_reg  <= ol_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;
    assign out_user  = ou_reg;
    assign out_last  = ol_reg;

endmodule : swpfc_back

`default_nettype wire

FILE: design/single_wire_pulse_frame_codec_top.sv
// ----------------------------------------------------------------------------
// single_wire_pulse_frame_codec_top
// Bit and frame codec for a single-wire debug link.
// ----------------------------------------------------------------------------
// Slave stream: one request per cycle while the queue has room; tuser = kind,
// tdata = payload and pulse width. Calibrate yields one status result,
// header five symbols and byte ten symbols (tlast on the final one of each),
// a pulse that completes an armed receive one done result; arm, other pulses
// and unused kinds yield nothing. Master stream: one result per cycle from an
// output register while the receiver is ready. Config channel: cfg_index 0
// sync min, 1 sync max; always ready. Write only while the block is idle.
// Path from request to first result: front, 4-deep command queue, symbol
// shifter, output register. Throughput is one result per cycle while the
// receiver is ready, set by the single output register; the front takes a
// request whenever the queue has room, and frames then leave the back one
// symbol per result.
// Reset clears receive state, threshold, queue and output valid; the sync bounds
// return to 50 and 1000. When the receiver stalls the output register holds,
// the back part stops, and the front keeps taking requests until the queue
// fills.
// ----------------------------------------------------------------------------
`default_nettype none

module single_wire_pulse_frame_codec_top
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic                                cfg_index,
    input  wire logic [15:0]                         cfg_data,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [swpfc_pkg::IN_DATA_W-1:0]     s_tdata,  // payload[7:0], pulse_width[23:8]
    input  wire logic [2:0]                          s_tuser,  // kind
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // status[0], sym_bit[1], rx_word[33:2], rx_ack[34], rx_data_byte[42:35],
    // rx_parity_ok[43], rx_start_ok[44], zero[47:45]
    output logic [swpfc_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic [swpfc_pkg::OUT_USER_W-1:0]         m_tuser,  // sym_valid[0], rx_done[1]
    output logic                                     m_tlast   // sym_last
);

    logic             q_full;
    logic             q_push;
    swpfc_pkg::cmd_t  q_cmd;
    logic             q_pop;
    logic             q_head_valid;
    swpfc_pkg::cmd_t  q_head;

    swpfc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .kind        (s_tuser),
        .payload     (s_tdata[7:0]),
        .pulse_width (s_tdata[23:8]),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    swpfc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head)
    );

    swpfc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_cmd   (q_head),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_user   (m_tuser),
        .out_last   (m_tlast)
    );

endmodule : single_wire_pulse_frame_codec_top

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the single-wire pulse and frame codec. A directed
// table covers sync bounds, frame extremes, arming corner cases and ignored
// kinds. Random frame, calibrate and receive sequences follow under several
// sync-bound settings and idling patterns. Every result is compared field by
// field with a local prediction of the codec.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import swpfc_pkg::*;

    // kinds the block ignores
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    localparam int N_DIRECTED  = 22;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 4000;
    localparam int SETTLE_CYC  = 10;

    typedef struct packed {
        logic        status;
        logic        sym_valid;
        logic        sym_bit;
        logic        sym_last;
        logic        rx_done;
        logic [31:0] rx_word;
        logic        rx_ack;
        logic [7:0]  rx_data_byte;
        logic        rx_parity_ok;
        logic        rx_start_ok;
    } link_result_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload;
        logic [15:0] width;
        logic        typed;         // status below is the expected one
        logic        status;
    } link_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_index;
    logic [15:0]           cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [2:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;

    // predicted codec state
    logic [15:0]           sync_min;
    logic [15:0]           sync_max;
    logic [10:0]           bit_thresh;
    logic                  rx_armed;
    logic [5:0]            rx_want;
    logic [5:0]            rx_got;
    logic [31:0]           rx_bits;

    link_result_t          pending_results[$];
    link_row_t             directed_rows [N_DIRECTED];
    int                    mismatch_count = 0;
    int                    useful_items   = 0;
    int                    snd_idle_pct   = 0;
    int                    rcv_idle_pct   = 0;
    int                    hold_asks      = 0;
    int                    hold_taken     = 0;
    int                    hold_left      = 0;
    int                    idle_cycles    = 0;

    single_wire_pulse_frame_codec_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #2 clk = ~clk;

    function automatic link_result_t frame_symbol(input logic bit_val, input logic last);
        link_result_t r;
        r = '0;
        r.sym_valid = 1'b1;
        r.sym_bit   = bit_val;
        r.sym_last  = last;
        return r;
    endfunction

    function automatic void predict_link_results(input logic [2:0] kind,
                                                 input logic [7:0] payload,
                                                 input logic [15:0] width,
                                                 ref link_result_t res[$]);
        link_result_t r;
        int           n;
        res.delete();
        r = '0;
        case (kind)
            KIND_CALIBRATE:
            begin
                if (width < sync_min || width > sync_max)
                    r.status = 1'b1;
                else
                    bit_thresh = 11'(width >> 5);
                res.push_back(r);
            end
            KIND_HEADER:
            begin
                res.push_back(frame_symbol(1'b0, 1'b0));
                for (int i = 1; i < HDR_SYMS; i++)
                    res.push_back(frame_symbol(payload[HDR_SYMS - 1 - i], i == HDR_SYMS - 1));
            end
            KIND_BYTE:
            begin
                res.push_back(frame_symbol(1'b0, 1'b0));
                for (int i = 1; i < BYTE_SYMS - 1; i++)
                    res.push_back(frame_symbol(payload[BYTE_SYMS - 2 - i], 1'b0));
                res.push_back(frame_symbol(^payload, 1'b1));
            end
            KIND_PULSE:
            begin
                if (rx_armed)
                begin
                    rx_bits = {rx_bits[30:0], width < {5'b0, bit_thresh}};
                    rx_got  = rx_got + 6'd1;
                    if (rx_got >= rx_want)
                    begin
                        rx_armed       = 1'b0;
                        r.rx_done      = 1'b1;
                        r.rx_word      = rx_bits;
                        r.rx_ack       = rx_bits[0];
                        r.rx_data_byte = rx_bits[8:1];
                        r.rx_parity_ok = rx_bits[0] == ^rx_bits[8:1];
                        r.rx_start_ok  = rx_bits[9];
                        res.push_back(r);
                    end
                end
            end
            KIND_ARM:
            begin
                n        = (payload > RX_BUF_SIZE) ? RX_BUF_SIZE : int'(payload);
                rx_want  = 6'(n);
                rx_got   = '0;
                rx_bits  = '0;
                rx_armed = n != 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        link_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing pending: tdata %0h tuser %0h", m_tdata, m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", want.status, m_tdata[0]);
                check_field("sym_valid", want.sym_valid, m_tuser[0]);
                check_field("sym_bit", want.sym_bit, m_tdata[1]);
                check_field("sym_last", want.sym_last, m_tlast);
                check_field("rx_done", want.rx_done, m_tuser[1]);
                check_field("rx_word", want.rx_word, m_tdata[33:2]);
                check_field("rx_ack", want.rx_ack, m_tdata[34]);
                check_field("rx_data_byte", want.rx_data_byte, m_tdata[42:35]);
                check_field("rx_parity_ok", want.rx_parity_ok, m_tdata[43]);
                check_field("rx_start_ok", want.rx_start_ok, m_tdata[44]);
                check_field("tdata pad", '0, m_tdata[47:45]);
            end
        end
    end

    // receiver side: random stalls plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_asks != hold_taken)
        begin
            hold_taken = hold_asks;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= $urandom_range(0, 99) >= rcv_idle_pct;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_request(input logic [2:0] kind, input logic [7:0] payload,
                                input logic [15:0] width, input logic typed = 1'b0,
                                input logic typed_status = 1'b0);
        link_result_t res[$];
        @(negedge clk);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {width, payload};
        do
            @(posedge clk);
        while (!s_tready);
        if (kind <= KIND_ARM && !(kind == KIND_PULSE && !rx_armed))
            useful_items++;
        predict_link_results(kind, payload, width, res);
        if (typed)
        begin
            res[0]        = '0;
            res[0].status = typed_status;
        end
        foreach (res[i])
            pending_results.push_back(res[i]);
    endtask

    task automatic write_sync_reg(input logic idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_SYNC_MIN)
            sync_min = value;
        else
            sync_max = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // an arm leaves nothing to wait for, so allow the pipeline to settle too
    task automatic wait_results_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    function automatic logic [15:0] near_bound(input logic [15:0] bound);
        int v;
        v = int'(bound) + $urandom_range(0, 4) - 2;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    function automatic logic [15:0] pick_sync_width();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 65535));
            1:       return near_bound(sync_min);
            2:       return near_bound(sync_max);
            default: return (sync_min <= sync_max) ? 16'($urandom_range(sync_max, sync_min))
                                                   : 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // short/long pulses around the current threshold, some anywhere
    function automatic logic [15:0] pick_pulse_width();
        case ($urandom_range(0, 2))
            0:       return 16'($urandom_range(0, 65535));
            1:       return (bit_thresh != 0) ? 16'($urandom_range(bit_thresh - 1, 0)) : 16'd0;
            default: return 16'($urandom_range(bit_thresh + 40, bit_thresh));
        endcase
    endfunction

    task automatic send_rx_sequence();
        int          pick;
        int          n;
        int          pulses;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            n = $urandom_range(1, 12);
        else if (pick < 8)
            n = 10;
        else if (pick < 9)
            n = $urandom_range(32, 255);
        else
            n = 0;
        send_request(KIND_ARM, 8'(n), 16'($urandom_range(0, 65535)));
        pulses = (n > RX_BUF_SIZE) ? RX_BUF_SIZE : n;
        for (int i = 0; i < pulses; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                // restart mid-collection
                send_request(KIND_ARM, 8'($urandom_range(0, 12)), 16'($urandom_range(0, 65535)));
                break;
            end
            send_request(KIND_PULSE, 8'($urandom_range(0, 255)), pick_pulse_width());
        end
    endtask

    task automatic run_random_items(input int target);
        int first;
        int pick;
        first = useful_items;
        while (useful_items - first < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_rx_sequence();
            else if (pick < 57)
                send_request(KIND_CALIBRATE, 8'($urandom_range(0, 255)), pick_sync_width());
            else if (pick < 70)
                send_request(KIND_HEADER, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            else if (pick < 84)
                send_request(KIND_BYTE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            else if (pick < 94)
                send_request(KIND_PULSE, 8'($urandom_range(0, 255)), pick_pulse_width());
            else
                send_request(3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO)),
                             8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_SYNC_MIN;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_CALIBRATE;
        m_tready   = 1'b0;
        sync_min   = SYNC_MIN_RESET;
        sync_max   = SYNC_MAX_RESET;
        bit_thresh = '0;
        rx_armed   = 1'b0;
        rx_want    = '0;
        rx_got     = '0;
        rx_bits    = '0;

        directed_rows = '{
            '{KIND_ARM,       8'h01, 16'h0000, 1'b0, 1'b0},
            '{KIND_PULSE,     8'h00, 16'h0000, 1'b0, 1'b0},  // zero threshold decodes 0
            '{KIND_PULSE,     8'h00, 16'h0000, 1'b0, 1'b0},  // unarmed, dropped
            '{KIND_CALIBRATE, 8'h00, 16'd49,   1'b1, 1'b1},
            '{KIND_CALIBRATE, 8'h00, 16'd1001, 1'b1, 1'b1},
            '{KIND_CALIBRATE, 8'hff, 16'hffff, 1'b1, 1'b1},
            '{KIND_CALIBRATE, 8'h00, 16'h0000, 1'b1, 1'b1},
            '{KIND_CALIBRATE, 8'h00, 16'd50,   1'b1, 1'b0},
            '{KIND_CALIBRATE, 8'h00, 16'd1000, 1'b1, 1'b0},  // threshold 31
            '{KIND_HEADER,    8'h0f, 16'h0000, 1'b0, 1'b0},
            '{KIND_HEADER,    8'hf0, 16'hffff, 1'b0, 1'b0},  // upper nibble ignored
            '{KIND_BYTE,      8'h00, 16'h0000, 1'b0, 1'b0},
            '{KIND_BYTE,      8'hff, 16'hffff, 1'b0, 1'b0},
            '{KIND_BYTE,      8'ha5, 16'h5a5a, 1'b0, 1'b0},
            '{KIND_ARM,       8'h00, 16'h0000, 1'b0, 1'b0},  // zero count stays unarmed
            '{KIND_PULSE,     8'h00, 16'h0000, 1'b0, 1'b0},
            '{KIND_ARM,       8'h03, 16'h0000, 1'b0, 1'b0},
            '{KIND_ARM,       8'h02, 16'h0000, 1'b0, 1'b0},  // re-arm restarts
            '{KIND_PULSE,     8'h00, 16'd30,   1'b0, 1'b0},  // just under threshold
            '{KIND_PULSE,     8'hff, 16'd31,   1'b0, 1'b0},  // at threshold: long
            '{KIND_SPARE_LO,  8'hff, 16'hffff, 1'b0, 1'b0},
            '{KIND_SPARE_HI,  8'h00, 16'h0000, 1'b0, 1'b0}
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        snd_idle_pct = 38;
        rcv_idle_pct = 81;
        foreach (directed_rows[i])
            send_request(directed_rows[i].kind, directed_rows[i].payload, directed_rows[i].width,
                         directed_rows[i].typed, directed_rows[i].status);
        run_random_items(60);
        wait_results_drained();

        write_sync_reg(CFG_SYNC_MIN, 16'h0000);
        write_sync_reg(CFG_SYNC_MAX, 16'hffff);
        run_random_items(60);
        wait_results_drained();

        snd_idle_pct = 81;
        rcv_idle_pct = 38;
        write_sync_reg(CFG_SYNC_MIN, 16'hffff);
        write_sync_reg(CFG_SYNC_MAX, 16'h0000);
        run_random_items(60);
        wait_results_drained();

        write_sync_reg(CFG_SYNC_MAX, 16'h0000);
        write_sync_reg(CFG_SYNC_MIN, 16'h0000);
        run_random_items(50);
        wait_results_drained();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_sync_reg(CFG_SYNC_MIN, 16'($urandom_range(0, 2000)));
        write_sync_reg(CFG_SYNC_MAX, 16'(sync_min + $urandom_range(0, 20000)));
        // long receiver hold while frames keep coming: queue fills, input stalls
        hold_asks++;
        repeat (8)
            send_request(KIND_BYTE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        run_random_items(60);
        wait_results_drained();

        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
